[hw/rtl/fts_pkg.sv]
package fts_pkg;

    // Default sizing of the thread pool and the mutex set
    localparam int POOL_THREADS_DEF = 4;
    localparam int MUTEX_COUNT_DEF  = 4;

    // Event codes
    localparam logic [2:0] MODE_SPAWN  = 3'd0;
    localparam logic [2:0] MODE_YIELD  = 3'd1;
    localparam logic [2:0] MODE_LOCK   = 3'd2;
    localparam logic [2:0] MODE_UNLOCK = 3'd3;
    localparam logic [2:0] MODE_FINISH = 3'd4;

    // Microprogram store
    localparam int PC_W      = 5;
    localparam int ROM_DEPTH = 28;
    typedef logic [PC_W-1:0] pc_t;

    // Micro-operations
    localparam logic [3:0] OP_DONE     = 4'd0;  // no datapath action
    localparam logic [3:0] OP_HALT     = 4'd1;  // set sticky halt
    localparam logic [3:0] OP_BRANCH   = 4'd2;  // jump to target when condition holds
    localparam logic [3:0] OP_POP      = 4'd3;  // take list head into CUR or TMP
    localparam logic [3:0] OP_PCLR     = 4'd4;  // push, first half: terminate link of item
    localparam logic [3:0] OP_PLNK     = 4'd5;  // push, second half: hook item at tail
    localparam logic [3:0] OP_MARK     = 4'd6;  // report TMP as the spawned slot
    localparam logic [3:0] OP_SETLOCK  = 4'd7;
    localparam logic [3:0] OP_CLRLOCK  = 4'd8;

    // List selection
    localparam logic [1:0] LST_FREE  = 2'd0;
    localparam logic [1:0] LST_READY = 2'd1;
    localparam logic [1:0] LST_WAIT  = 2'd2;

    // Operand selection
    localparam logic SEL_CUR = 1'b0;
    localparam logic SEL_TMP = 1'b1;

    // Branch conditions
    localparam logic [2:0] C_NONE        = 3'd0;
    localparam logic [2:0] C_FREE_EMPTY  = 3'd1;
    localparam logic [2:0] C_READY_EMPTY = 3'd2;
    localparam logic [2:0] C_WAIT_EMPTY  = 3'd3;
    localparam logic [2:0] C_LOCK_CLEAR  = 3'd4;
    localparam logic [2:0] C_CUR_MAIN    = 3'd5;
    localparam logic [2:0] C_MX_BAD      = 3'd6;

    // Program addresses
    localparam pc_t A_DONE       = 5'd0;
    localparam pc_t A_HALT       = 5'd1;
    localparam pc_t A_SPAWN      = 5'd2;
    localparam pc_t A_YIELD      = 5'd7;
    localparam pc_t A_LOCK       = 5'd10;
    localparam pc_t A_LOCK_SET   = 5'd16;
    localparam pc_t A_UNLOCK     = 5'd17;
    localparam pc_t A_UNLOCK_CLR = 5'd22;
    localparam pc_t A_FINISH     = 5'd23;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] lst;
        logic       sel;
        logic [2:0] cond;
        pc_t        target;
        logic       last;
    } uword_t;

    typedef struct packed {
        logic halted;
        logic free_empty;
        logic ready_empty;
        logic wait_empty;
        logic lock_clear;
        logic cur_main;
        logic mx_bad;
    } status_t;

    typedef struct packed {
        logic       start;
        logic       exec;
        logic [1:0] mx;
        uword_t     uw;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] mutex_index;
    } ev_t;

    typedef struct packed {
        logic [2:0] running_thread;
        logic [1:0] new_thread;
        logic       halted;
    } res_t;

    function automatic uword_t uw(input logic [3:0] op, input logic [1:0] lst,
                                  input logic sel, input logic [2:0] cond,
                                  input pc_t target, input logic last);
        uword_t w;
        w.op     = op;
        w.lst    = lst;
        w.sel    = sel;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        unique case (pc)
            5'd0:  w = uw(OP_DONE,    LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
            5'd1:  w = uw(OP_HALT,    LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
            // spawn
            5'd2:  w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_FREE_EMPTY,  A_HALT,       1'b0);
            5'd3:  w = uw(OP_POP,     LST_FREE,  SEL_TMP, C_NONE,        A_DONE,       1'b0);
            5'd4:  w = uw(OP_PCLR,    LST_READY, SEL_TMP, C_NONE,        A_DONE,       1'b0);
            5'd5:  w = uw(OP_PLNK,    LST_READY, SEL_TMP, C_NONE,        A_DONE,       1'b0);
            5'd6:  w = uw(OP_MARK,    LST_FREE,  SEL_TMP, C_NONE,        A_DONE,       1'b1);
            // yield
            5'd7:  w = uw(OP_PCLR,    LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd8:  w = uw(OP_PLNK,    LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd9:  w = uw(OP_POP,     LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b1);
            // lock
            5'd10: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_MX_BAD,      A_DONE,       1'b0);
            5'd11: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_LOCK_CLEAR,  A_LOCK_SET,   1'b0);
            5'd12: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_READY_EMPTY, A_HALT,       1'b0);
            5'd13: w = uw(OP_PCLR,    LST_WAIT,  SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd14: w = uw(OP_PLNK,    LST_WAIT,  SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd15: w = uw(OP_POP,     LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b1);
            5'd16: w = uw(OP_SETLOCK, LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
            // unlock
            5'd17: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_MX_BAD,      A_DONE,       1'b0);
            5'd18: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_WAIT_EMPTY,  A_UNLOCK_CLR, 1'b0);
            5'd19: w = uw(OP_PCLR,    LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd20: w = uw(OP_PLNK,    LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd21: w = uw(OP_POP,     LST_WAIT,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
            5'd22: w = uw(OP_CLRLOCK, LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
            // finish
            5'd23: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_CUR_MAIN,    A_DONE,       1'b0);
            5'd24: w = uw(OP_BRANCH,  LST_FREE,  SEL_CUR, C_READY_EMPTY, A_HALT,       1'b0);
            5'd25: w = uw(OP_PCLR,    LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd26: w = uw(OP_PLNK,    LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b0);
            5'd27: w = uw(OP_POP,     LST_READY, SEL_CUR, C_NONE,        A_DONE,       1'b1);
            default: w = uw(OP_DONE,  LST_FREE,  SEL_CUR, C_NONE,        A_DONE,       1'b1);
        endcase
        return w;
    endfunction

    function automatic pc_t entry_pc(input logic [2:0] mode, input logic halted);
        pc_t e;
        if (halted) begin
            e = A_DONE;
        end
        else begin
            unique case (mode)
                MODE_SPAWN:  e = A_SPAWN;
                MODE_YIELD:  e = A_YIELD;
                MODE_LOCK:   e = A_LOCK;
                MODE_UNLOCK: e = A_UNLOCK;
                MODE_FINISH: e = A_FINISH;
                default:     e = A_DONE;
            endcase
        end
        return e;
    endfunction

    function automatic logic cond_true(input logic [2:0] c, input status_t s);
        logic r;
        unique case (c)
            C_FREE_EMPTY:  r = s.free_empty;
            C_READY_EMPTY: r = s.ready_empty;
            C_WAIT_EMPTY:  r = s.wait_empty;
            C_LOCK_CLEAR:  r = s.lock_clear;
            C_CUR_MAIN:    r = s.cur_main;
            C_MX_BAD:      r = s.mx_bad;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/fifo_thread_scheduler_with_mutexes_unit.sv]
// Round-robin thread scheduler with mutexes.
// Event channel (ev_valid / ev_ready / ev_data): one transfer per scheduling
// event, mode 0 spawn, 1 yield or timer tick, 2 lock, 3 unlock, 4 finish;
// mutex_index names the mutex for lock and unlock.
// Result channel (res_valid / res_ready / res_data): one transfer per event
// with the running thread, the slot taken by a spawn (zero otherwise) and
// the sticky halted flag.
// Timing: an event runs a short microprogram from a constant control store,
// one control word per cycle. The program has n = 1 to 6 steps (6 for a
// lock that blocks, 5 for spawn, finish and an unlock that hands over the
// mutex, 3 for yield, 1 for an unused mode or an event that arrives once
// halted); the result is then registered at write-back. The next event is
// taken once the sequencer has left write-back and is idle again.
// Reset: all threads slots sit on the free list, the main thread runs, all
// mutexes are open, no result is pending.
// Stall: a result waits in its output register while the next event is
// taken and run; the program then holds at write-back until the pending
// result transfers.
module fifo_thread_scheduler_with_mutexes_unit #(
    parameter int POOL_THREADS = fts_pkg::POOL_THREADS_DEF,
    parameter int MUTEX_COUNT  = fts_pkg::MUTEX_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ev_valid,
    output logic          ev_ready,
    input  fts_pkg::ev_t  ev_data,
    output logic          res_valid,
    input  logic          res_ready,
    output fts_pkg::res_t res_data
);

    // control words flow down, condition flags flow up
    fts_pkg::ctrl_t   ctrl;
    fts_pkg::status_t status;
    fts_pkg::res_t    dp_result;

    fts_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .status    (status),
        .dp_result (dp_result),
        .ctrl      (ctrl)
    );

    // list registers, link table, lock flags and halt state
    fts_datapath #(
        .POOL_THREADS (POOL_THREADS),
        .MUTEX_COUNT  (MUTEX_COUNT)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .result (dp_result)
    );

endmodule

[hw/rtl/fts_sequencer.sv]
module fts_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ev_valid,
    output logic             ev_ready,
    input  fts_pkg::ev_t     ev_data,
    output logic             res_valid,
    input  logic             res_ready,
    output fts_pkg::res_t    res_data,
    input  fts_pkg::status_t status,
    input  fts_pkg::res_t    dp_result,
    output fts_pkg::ctrl_t   ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]       state_reg, state_next;
    fts_pkg::pc_t     pc_reg, pc_next;
    logic             res_valid_reg, res_valid_next;
    fts_pkg::res_t    res_data_reg, res_data_next;
    fts_pkg::uword_t  uword;
    logic             accept;

    assign uword    = fts_pkg::ucode_rom(pc_reg);
    assign ev_ready = (state_reg == ST_IDLE);
    assign accept   = ev_valid && ev_ready;

    assign ctrl.start = accept;
    assign ctrl.exec  = (state_reg == ST_RUN);
    assign ctrl.mx    = ev_data.mutex_index;
    assign ctrl.uw    = uword;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pc_next    = fts_pkg::entry_pc(ev_data.mode, status.halted);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (uword.op == fts_pkg::OP_BRANCH && fts_pkg::cond_true(uword.cond, status))
                begin
                    pc_next = uword.target;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
                if (uword.last)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                // hold until the result slot is free
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = dp_result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= fts_pkg::A_DONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready |=> state_reg == ST_RUN)
        else $error("accepted event did not start the program");

    a_pc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> int'(pc_reg) < fts_pkg::ROM_DEPTH)
        else $error("program counter left the microcode store");

    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_WB)
        else $error("result raised outside write-back");

endmodule

[hw/rtl/fts_datapath.sv]
module fts_datapath #(
    parameter int POOL_THREADS = fts_pkg::POOL_THREADS_DEF,
    parameter int MUTEX_COUNT  = fts_pkg::MUTEX_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fts_pkg::ctrl_t   ctrl,
    output fts_pkg::status_t status,
    output fts_pkg::res_t    result
);

    localparam int LINKS = POOL_THREADS + 1;
    localparam int ID_W  = $clog2(POOL_THREADS + 2);
    localparam int LI_W  = $clog2(LINKS);
    localparam int MX_W  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

    typedef logic [ID_W-1:0] id_t;

    localparam id_t NIL_ID   = ID_W'(POOL_THREADS + 1);
    localparam id_t MAIN_ID  = ID_W'(POOL_THREADS);
    localparam id_t LINKS_ID = ID_W'(LINKS);

    id_t link_reg [LINKS];
    id_t link_next[LINKS];
    id_t wait_head_reg [MUTEX_COUNT];
    id_t wait_head_next[MUTEX_COUNT];
    id_t wait_tail_reg [MUTEX_COUNT];
    id_t wait_tail_next[MUTEX_COUNT];
    logic [MUTEX_COUNT-1:0] lock_reg, lock_next;

    id_t cur_reg, cur_next;
    id_t tmp_reg, tmp_next;
    id_t new_reg, new_next;
    id_t free_head_reg, free_head_next, free_tail_reg, free_tail_next;
    id_t ready_head_reg, ready_head_next, ready_tail_reg, ready_tail_next;
    logic halt_reg, halt_next;
    logic [1:0] mx_reg, mx_next;

    logic            mx_ok;
    logic [MX_W-1:0] mx_idx;
    id_t             wait_head_sel, wait_tail_sel;
    id_t             src, head_sel, tail_sel, popped, nh;
    id_t             head_new, tail_new;
    logic            head_we, tail_we;
    fts_pkg::uword_t uw;

    assign uw     = ctrl.uw;
    assign mx_ok  = (int'(mx_reg) < MUTEX_COUNT);
    assign mx_idx = MX_W'(mx_reg);
    assign wait_head_sel = mx_ok ? wait_head_reg[mx_idx] : NIL_ID;
    assign wait_tail_sel = mx_ok ? wait_tail_reg[mx_idx] : NIL_ID;
    assign src = (uw.sel == fts_pkg::SEL_CUR) ? cur_reg : tmp_reg;

    assign status.halted      = halt_reg;
    assign status.free_empty  = (free_head_reg >= LINKS_ID);
    assign status.ready_empty = (ready_head_reg >= LINKS_ID);
    assign status.wait_empty  = (wait_head_sel >= LINKS_ID);
    assign status.lock_clear  = mx_ok ? !lock_reg[mx_idx] : 1'b0;
    assign status.cur_main    = (cur_reg >= MAIN_ID);
    assign status.mx_bad      = !mx_ok;

    assign result.running_thread = 3'(cur_reg);
    assign result.new_thread     = 2'(new_reg);
    assign result.halted         = halt_reg;

    always_comb
    begin
        unique case (uw.lst)
            fts_pkg::LST_FREE:
            begin
                head_sel = free_head_reg;
                tail_sel = free_tail_reg;
            end
            fts_pkg::LST_READY:
            begin
                head_sel = ready_head_reg;
                tail_sel = ready_tail_reg;
            end
            fts_pkg::LST_WAIT:
            begin
                head_sel = wait_head_sel;
                tail_sel = wait_tail_sel;
            end
            default:
            begin
                head_sel = NIL_ID;
                tail_sel = NIL_ID;
            end
        endcase
    end

    always_comb
    begin
        link_next       = link_reg;
        wait_head_next  = wait_head_reg;
        wait_tail_next  = wait_tail_reg;
        lock_next       = lock_reg;
        cur_next        = cur_reg;
        tmp_next        = tmp_reg;
        new_next        = new_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        ready_head_next = ready_head_reg;
        ready_tail_next = ready_tail_reg;
        halt_next       = halt_reg;
        mx_next         = mx_reg;
        head_new        = NIL_ID;
        tail_new        = NIL_ID;
        head_we         = 1'b0;
        tail_we         = 1'b0;
        popped          = NIL_ID;
        nh              = NIL_ID;

        if (ctrl.start)
        begin
            mx_next  = ctrl.mx;
            new_next = '0;
        end

        if (ctrl.exec)
        begin
            unique case (uw.op)
                fts_pkg::OP_PCLR:
                begin
                    if (src < LINKS_ID)
                    begin
                        link_next[src[LI_W-1:0]] = NIL_ID;
                    end
                end
                fts_pkg::OP_PLNK:
                begin
                    if (src < LINKS_ID)
                    begin
                        if (head_sel >= LINKS_ID)
                        begin
                            head_new = src;
                            head_we  = 1'b1;
                        end
                        else if (tail_sel < LINKS_ID)
                        begin
                            link_next[tail_sel[LI_W-1:0]] = src;
                        end
                        tail_new = src;
                        tail_we  = 1'b1;
                    end
                end
                fts_pkg::OP_POP:
                begin
                    if (head_sel < LINKS_ID)
                    begin
                        popped  = head_sel;
                        nh      = link_reg[head_sel[LI_W-1:0]];
                        head_we = 1'b1;
                        if (nh >= LINKS_ID)
                        begin
                            head_new = NIL_ID;
                            tail_new = NIL_ID;
                            tail_we  = 1'b1;
                        end
                        else
                        begin
                            head_new = nh;
                        end
                    end
                    if (uw.sel == fts_pkg::SEL_CUR)
                    begin
                        cur_next = popped;
                    end
                    else
                    begin
                        tmp_next = popped;
                    end
                end
                fts_pkg::OP_MARK:
                begin
                    new_next = tmp_reg;
                end
                fts_pkg::OP_HALT:
                begin
                    halt_next = 1'b1;
                end
                fts_pkg::OP_SETLOCK:
                begin
                    if (mx_ok)
                    begin
                        lock_next[mx_idx] = 1'b1;
                    end
                end
                fts_pkg::OP_CLRLOCK:
                begin
                    if (mx_ok)
                    begin
                        lock_next[mx_idx] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // write back head and tail of the selected list
        unique case (uw.lst)
            fts_pkg::LST_FREE:
            begin
                if (head_we) free_head_next = head_new;
                if (tail_we) free_tail_next = tail_new;
            end
            fts_pkg::LST_READY:
            begin
                if (head_we) ready_head_next = head_new;
                if (tail_we) ready_tail_next = tail_new;
            end
            fts_pkg::LST_WAIT:
            begin
                if (mx_ok)
                begin
                    if (head_we) wait_head_next[mx_idx] = head_new;
                    if (tail_we) wait_tail_next[mx_idx] = tail_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINKS; i++)
            begin
                link_reg[i] <= (i + 1 < POOL_THREADS) ? ID_W'(i + 1) : NIL_ID;
            end
            for (int m = 0; m < MUTEX_COUNT; m++)
            begin
                wait_head_reg[m] <= NIL_ID;
                wait_tail_reg[m] <= NIL_ID;
            end
            lock_reg       <= '0;
            cur_reg        <= MAIN_ID;
            tmp_reg        <= NIL_ID;
            new_reg        <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= ID_W'(POOL_THREADS - 1);
            ready_head_reg <= NIL_ID;
            ready_tail_reg <= NIL_ID;
            halt_reg       <= 1'b0;
            mx_reg         <= '0;
        end
        else
        begin
            link_reg       <= link_next;
            wait_head_reg  <= wait_head_next;
            wait_tail_reg  <= wait_tail_next;
            lock_reg       <= lock_next;
            cur_reg        <= cur_next;
            tmp_reg        <= tmp_next;
            new_reg        <= new_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            ready_head_reg <= ready_head_next;
            ready_tail_reg <= ready_tail_next;
            halt_reg       <= halt_next;
            mx_reg         <= mx_next;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped");

    a_ready_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_head_reg >= LINKS_ID) == (ready_tail_reg >= LINKS_ID))
        else $error("ready queue head and tail disagree on emptiness");

    a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg < LINKS_ID)
        else $error("running thread is the null link");

endmodule
